// ===== src/sjcd_pkg.sv =====
// Package of the serial joystick command decoder.
// Holds the queue item types, character codes, arithmetic constants and the sine table.
// No dependencies.
`default_nettype none

package sjcd_pkg;

	localparam logic KIND_KEY = 1'b0;
	localparam logic KIND_JOY = 1'b1;

	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_B  = 8'h42;
	localparam logic [7:0] CH_UP_D  = 8'h44;
	localparam logic [7:0] CH_UP_F  = 8'h46;
	localparam logic [7:0] CH_UP_L  = 8'h4C;
	localparam logic [7:0] CH_UP_P  = 8'h50;
	localparam logic [7:0] CH_UP_R  = 8'h52;
	localparam logic [7:0] CH_UP_S  = 8'h53;
	localparam logic [7:0] CH_UP_U  = 8'h55;
	localparam logic [7:0] CH_UP_W  = 8'h57;
	localparam logic [7:0] CH_UP_X  = 8'h58;
	localparam logic [7:0] CH_UP_Y  = 8'h59;
	localparam logic [7:0] CH_UP_Z  = 8'h5A;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_Z  = 8'h7A;
	localparam logic [7:0] CASE_GAP = 8'h20;

	localparam logic [8:0] ANGLE_MAX = 9'd359;

	// Speed = round(s * power * 100 / (99 * 32768)), done as
	// floor(floor((200 * s * power + 99 * 32768) / 65536) / 99).
	localparam logic [29:0] NUM_GAIN   = 30'd200;
	localparam logic [29:0] ROUND_BIAS = 30'd3244032;
	localparam logic [13:0] RECIP_99   = 14'd10592;

	localparam logic [14:0] SINE_Q15 [91] = '{
		15'd0,     15'd572,   15'd1144,  15'd1715,  15'd2286,
		15'd2856,  15'd3425,  15'd3993,  15'd4560,  15'd5126,
		15'd5690,  15'd6252,  15'd6813,  15'd7371,  15'd7927,
		15'd8481,  15'd9032,  15'd9580,  15'd10126, 15'd10668,
		15'd11207, 15'd11743, 15'd12275, 15'd12803, 15'd13328,
		15'd13848, 15'd14365, 15'd14876, 15'd15384, 15'd15886,
		15'd16384, 15'd16877, 15'd17364, 15'd17847, 15'd18324,
		15'd18795, 15'd19261, 15'd19720, 15'd20174, 15'd20622,
		15'd21063, 15'd21498, 15'd21926, 15'd22348, 15'd22763,
		15'd23170, 15'd23571, 15'd23965, 15'd24351, 15'd24730,
		15'd25102, 15'd25466, 15'd25822, 15'd26170, 15'd26510,
		15'd26842, 15'd27166, 15'd27482, 15'd27789, 15'd28088,
		15'd28378, 15'd28660, 15'd28932, 15'd29197, 15'd29452,
		15'd29698, 15'd29935, 15'd30163, 15'd30382, 15'd30592,
		15'd30792, 15'd30983, 15'd31164, 15'd31336, 15'd31499,
		15'd31651, 15'd31795, 15'd31928, 15'd32052, 15'd32166,
		15'd32270, 15'd32365, 15'd32449, 15'd32524, 15'd32589,
		15'd32643, 15'd32688, 15'd32723, 15'd32748, 15'd32763,
		15'd32767
	};

	typedef struct packed {
		logic       kind;
		logic [7:0] key;
		logic [8:0] angle;
		logic [6:0] power;
	} cmd_t;

	typedef struct packed {
		logic              kind;
		logic [7:0]        key;
		logic signed [7:0] straight;
		logic signed [7:0] turn;
	} res_t;

	function automatic logic [14:0] sine_lookup(input logic [6:0] idx);
		logic [14:0] val;
		val = '0;
		if (idx <= 7'd90) begin
			val = SINE_Q15[idx];
		end
		return val;
	endfunction

	function automatic logic is_key(input logic [7:0] c);
		return c == CH_UP_F || c == CH_UP_B || c == CH_UP_L || c == CH_UP_R ||
			c == CH_UP_W || c == CH_UP_X || c == CH_UP_Y || c == CH_UP_Z ||
			c == CH_UP_U || c == CH_UP_S || c == CH_UP_D;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

endpackage

`default_nettype wire

// ===== src/sjcd_fifo.sv =====
// Small register queue with a count, used between the decoder stages.
// Generic in width and depth; no package dependency.
`default_nettype none

module sjcd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rdata,
	output logic                  empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = count_q == CNT_W'(DEPTH);
	assign empty   = count_q == '0;
	assign do_pop  = pop && !empty;
	assign do_push = push && (!full || do_pop);
	assign rdata   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

`default_nettype wire

// ===== src/sjcd_front.sv =====
// Front part of the decoder: folds case, tracks text lines and joystick frames.
// Emits key and frame commands as sjcd_pkg::cmd_t items; uses sjcd_pkg.
`default_nettype none

module sjcd_front #(
	parameter int FRAME_BUF_DEPTH = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          take,
	input  wire logic [7:0]    rx_byte,
	input  wire logic          cfg_wr_en,
	input  wire logic          cfg_wr_data,
	output logic               cmd_push,
	output sjcd_pkg::cmd_t     cmd
);

	localparam int CNT_W = $clog2(FRAME_BUF_DEPTH + 1);

	logic             joy_en_q;
	logic             text_mode_q;
	logic [1:0]       line_cnt_q;
	logic [7:0]       line_first_q;
	logic [CNT_W-1:0] frame_cnt_q;
	logic [7:0]       frame_byte_q [1:6];

	logic             text_mode_d;
	logic [1:0]       line_cnt_d;
	logic [7:0]       line_first_d;
	logic [CNT_W-1:0] frame_cnt_d;
	logic             store_en;
	logic [7:0]       c;
	logic             line_end;
	logic [CNT_W-1:0] cnt_inc;
	logic             frame_ok;
	logic [3:0]       d1, d2, d3, d5, d6;
	logic [9:0]       angle;
	logic [6:0]       power;

	always_comb begin
		c = rx_byte;
		if (rx_byte >= sjcd_pkg::CH_LO_A && rx_byte <= sjcd_pkg::CH_LO_Z) begin
			c = rx_byte - sjcd_pkg::CASE_GAP;
		end
	end

	assign line_end = c == sjcd_pkg::CH_CR || c == sjcd_pkg::CH_LF;
	assign cnt_inc  = frame_cnt_q + 1'b1;

	assign d1 = 4'(frame_byte_q[1] - sjcd_pkg::CH_ZERO);
	assign d2 = 4'(frame_byte_q[2] - sjcd_pkg::CH_ZERO);
	assign d3 = 4'(frame_byte_q[3] - sjcd_pkg::CH_ZERO);
	assign d5 = 4'(frame_byte_q[5] - sjcd_pkg::CH_ZERO);
	assign d6 = 4'(frame_byte_q[6] - sjcd_pkg::CH_ZERO);
	assign angle = 10'(d1) * 10'd100 + 10'(d2) * 10'd10 + 10'(d3);
	assign power = 7'(d5) * 7'd10 + 7'(d6);

	// A frame counts its terminator, so eight bytes means seven already stored.
	assign frame_ok = frame_cnt_q >= CNT_W'(7) &&
		frame_byte_q[4] == sjcd_pkg::CH_UP_P &&
		sjcd_pkg::is_digit(frame_byte_q[1]) && sjcd_pkg::is_digit(frame_byte_q[2]) &&
		sjcd_pkg::is_digit(frame_byte_q[3]) && sjcd_pkg::is_digit(frame_byte_q[5]) &&
		sjcd_pkg::is_digit(frame_byte_q[6]) && angle <= 10'(sjcd_pkg::ANGLE_MAX);

	always_comb begin
		text_mode_d  = text_mode_q;
		line_cnt_d   = line_cnt_q;
		line_first_d = line_first_q;
		frame_cnt_d  = frame_cnt_q;
		store_en     = 1'b0;
		cmd_push     = 1'b0;
		cmd.kind     = sjcd_pkg::KIND_KEY;
		cmd.key      = (line_first_q == sjcd_pkg::CH_UP_D) ? sjcd_pkg::CH_UP_B : line_first_q;
		cmd.angle    = '0;
		cmd.power    = '0;
		if (take) begin
			if (text_mode_q) begin
				if (line_end) begin
					cmd_push     = line_cnt_q == 2'd1 && sjcd_pkg::is_key(line_first_q);
					text_mode_d  = 1'b0;
					line_cnt_d   = '0;
					line_first_d = '0;
				end else if (line_cnt_q < 2'd2) begin
					if (line_cnt_q == 2'd0) begin
						line_first_d = c;
					end
					line_cnt_d = line_cnt_q + 1'b1;
				end
			end else if (frame_cnt_q == '0 && line_end) begin
				text_mode_d = 1'b0;
			end else if (c == sjcd_pkg::CH_UP_A && joy_en_q) begin
				frame_cnt_d = CNT_W'(1);
			end else if (frame_cnt_q != '0) begin
				store_en = 1'b1;
				if (line_end) begin
					frame_cnt_d = '0;
					cmd_push    = frame_ok;
					cmd.kind    = sjcd_pkg::KIND_JOY;
					cmd.key     = '0;
					cmd.angle   = angle[8:0];
					cmd.power   = power;
				end else if (cnt_inc == CNT_W'(FRAME_BUF_DEPTH)) begin
					frame_cnt_d = '0;
					text_mode_d = 1'b1;
				end else begin
					frame_cnt_d = cnt_inc;
				end
			end else begin
				text_mode_d  = 1'b1;
				line_first_d = c;
				line_cnt_d   = 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			joy_en_q     <= 1'b1;
			text_mode_q  <= 1'b0;
			line_cnt_q   <= '0;
			line_first_q <= '0;
			frame_cnt_q  <= '0;
		end else begin
			text_mode_q  <= text_mode_d;
			line_cnt_q   <= line_cnt_d;
			line_first_q <= line_first_d;
			if (cfg_wr_en) begin
				joy_en_q    <= cfg_wr_data;
				frame_cnt_q <= '0;
			end else begin
				frame_cnt_q <= frame_cnt_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 1; i <= 6; i++) begin
			if (store_en && frame_cnt_q == CNT_W'(i)) begin
				frame_byte_q[i] <= c;
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/sjcd_back.sv =====
// Back part of the decoder: turns frame commands into speed pairs and passes key commands through, in five stages.
// Quadrant split, sine lookup, power multiply, rounding, reciprocal divide by 99; uses sjcd_pkg.
`default_nettype none

module sjcd_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cmd_valid,
	input  wire sjcd_pkg::cmd_t cmd,
	output logic                cmd_pop,
	input  wire logic           res_ready,
	output logic                res_push,
	output sjcd_pkg::res_t      res
);

	logic        advance;

	logic        v_s1, v_s2, v_s3, v_s4, v_s5;
	logic        kind_s1, kind_s2, kind_s3, kind_s4, kind_s5;
	logic [7:0]  key_s1, key_s2, key_s3, key_s4, key_s5;
	logic [1:0]  quad_s1;
	logic [6:0]  rem_s1;
	logic [6:0]  power_s1, power_s2;
	logic [14:0] mag_s2 [2];
	logic        neg_s2 [2];
	logic        neg_s3 [2];
	logic        neg_s4 [2];
	logic        neg_s5 [2];
	logic [21:0] prod_s3 [2];
	logic [13:0] y_s4 [2];
	logic [26:0] quot_s5 [2];

	logic [1:0]  quad_d;
	logic [8:0]  rem_d;
	logic [14:0] mag_d [2];
	logic        neg_d [2];
	logic [29:0] num_d [2];
	logic [7:0]  speed [2];

	assign advance  = !v_s5 || res_ready;
	assign cmd_pop  = advance && cmd_valid;
	assign res_push = v_s5 && res_ready;

	always_comb begin
		if (cmd.angle >= 9'd270) begin
			quad_d = 2'd3;
			rem_d  = cmd.angle - 9'd270;
		end else if (cmd.angle >= 9'd180) begin
			quad_d = 2'd2;
			rem_d  = cmd.angle - 9'd180;
		end else if (cmd.angle >= 9'd90) begin
			quad_d = 2'd1;
			rem_d  = cmd.angle - 9'd90;
		end else begin
			quad_d = 2'd0;
			rem_d  = cmd.angle;
		end
	end

	// Lane 0 is the sine (straight), lane 1 the cosine (turn) one quadrant on.
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			logic [1:0] qq;
			qq       = quad_s1 + 2'(l);
			mag_d[l] = sjcd_pkg::sine_lookup(qq[0] ? (7'd90 - rem_s1) : rem_s1);
			neg_d[l] = qq[1];
			num_d[l] = 30'(prod_s3[l]) * sjcd_pkg::NUM_GAIN + sjcd_pkg::ROUND_BIAS;
			speed[l] = neg_s5[l] ? (8'd0 - {1'b0, quot_s5[l][26:20]}) :
				{1'b0, quot_s5[l][26:20]};
		end
	end

	always_comb begin
		res.kind     = kind_s5;
		res.key      = (kind_s5 == sjcd_pkg::KIND_KEY) ? key_s5 : 8'd0;
		res.straight = (kind_s5 == sjcd_pkg::KIND_JOY) ? $signed(speed[0]) : 8'sd0;
		res.turn     = (kind_s5 == sjcd_pkg::KIND_JOY) ? $signed(speed[1]) : 8'sd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (advance) begin
			v_s1 <= cmd_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			kind_s1  <= cmd.kind;
			key_s1   <= cmd.key;
			quad_s1  <= quad_d;
			rem_s1   <= rem_d[6:0];
			power_s1 <= cmd.power;

			kind_s2  <= kind_s1;
			key_s2   <= key_s1;
			power_s2 <= power_s1;

			kind_s3  <= kind_s2;
			key_s3   <= key_s2;
			kind_s4  <= kind_s3;
			key_s4   <= key_s3;
			kind_s5  <= kind_s4;
			key_s5   <= key_s4;

			for (int l = 0; l < 2; l++) begin
				mag_s2[l]  <= mag_d[l];
				neg_s2[l]  <= neg_d[l];
				prod_s3[l] <= {7'd0, mag_s2[l]} * {15'd0, power_s2};
				neg_s3[l]  <= neg_s2[l];
				y_s4[l]    <= num_d[l][29:16];
				neg_s4[l]  <= neg_s3[l];
				quot_s5[l] <= {13'd0, y_s4[l]} * {13'd0, sjcd_pkg::RECIP_99};
				neg_s5[l]  <= neg_s4[l];
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/serial_joystick_command_decoder_top.sv =====
// Top level of the serial joystick command decoder.
// Connects sjcd_front, two sjcd_fifo queues and sjcd_back; uses sjcd_pkg.
//
//   channel   handshake            payload
//   input     push / full          rx_byte
//   result    empty / pop          result_kind, key_code, straight_speed, turn_speed
//   config    cfg_wr_en            cfg_wr_data (joystick_enable)
//
// One byte is taken per cycle while full is low; full rises only when the command
// queue between front and back is full. A result reaches the output queue from its
// closing byte through the command queue and the five back stages.
// The back stages stall together only when the output queue is full and not popped.
// Reset is asynchronous and leaves joystick mode on with no frame or line open.
`default_nettype none

module serial_joystick_command_decoder_top #(
	parameter int FRAME_BUF_DEPTH = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	output logic                   full,
	input  wire logic        [7:0] rx_byte,
	input  wire logic              cfg_wr_en,
	input  wire logic              cfg_wr_data,
	output logic                   empty,
	input  wire logic              pop,
	output logic                   result_kind,
	output logic             [7:0] key_code,
	output logic signed      [7:0] straight_speed,
	output logic signed      [7:0] turn_speed
);

	localparam int CMD_DEPTH = 2;
	localparam int RES_DEPTH = 2;
	localparam int CMD_W     = $bits(sjcd_pkg::cmd_t);
	localparam int RES_W     = $bits(sjcd_pkg::res_t);

	logic           take;
	logic           cmd_push;
	sjcd_pkg::cmd_t cmd_in;
	sjcd_pkg::cmd_t cmd_out;
	logic           cmd_empty;
	logic           cmd_pop;
	logic           res_push;
	logic           res_ready;
	logic           res_full;
	sjcd_pkg::res_t res_in;
	sjcd_pkg::res_t res_out;

	assign take      = push && !full;
	assign res_ready = !res_full || (pop && !empty);

	sjcd_front #(
		.FRAME_BUF_DEPTH(FRAME_BUF_DEPTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.rx_byte     (rx_byte),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd_push    (cmd_push),
		.cmd         (cmd_in)
	);

	sjcd_fifo #(
		.WIDTH(CMD_W),
		.DEPTH(CMD_DEPTH)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_in),
		.full   (full),
		.pop    (cmd_pop),
		.rdata  (cmd_out),
		.empty  (cmd_empty)
	);

	sjcd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (!cmd_empty),
		.cmd       (cmd_out),
		.cmd_pop   (cmd_pop),
		.res_ready (res_ready),
		.res_push  (res_push),
		.res       (res_in)
	);

	sjcd_fifo #(
		.WIDTH(RES_W),
		.DEPTH(RES_DEPTH)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_out),
		.empty  (empty)
	);

	assign result_kind    = res_out.kind;
	assign key_code       = res_out.key;
	assign straight_speed = res_out.straight;
	assign turn_speed     = res_out.turn;

endmodule

`default_nettype wire

// ===== sim/serial_joystick_command_decoder_top_tb.sv =====
// Testbench of serial_joystick_command_decoder_top: sends byte streams of key lines,
// joystick frames and noise, predicts each key or speed pair and checks it at the output.
// Depends on sjcd_pkg and the decoder RTL only.

module serial_joystick_command_decoder_top_tb;

	localparam int CLK_PERIOD   = 8;
	localparam int RESET_CYCLES = 9;
	localparam int FRAME_DEPTH  = 16;
	localparam int DRAIN_CYCLES = 16;
	localparam int HOLD_CYCLES  = 400;
	localparam int QUIET_LIMIT  = 3000;
	localparam longint SPEED_DEN = 99 * 32768;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       push;
	logic       full;
	logic [7:0] rx_byte;
	logic       cfg_wr_en;
	logic       cfg_wr_data;
	logic       empty;
	logic       pop;
	logic       result_kind;
	logic [7:0] key_code;
	logic signed [7:0] straight_speed;
	logic signed [7:0] turn_speed;

	logic [7:0]     tx_bytes [$];
	sjcd_pkg::res_t awaited [$];

	int send_idle_pct;
	int recv_idle_pct;
	int hold_requests = 0;
	int holds_served  = 0;
	int hold_left     = 0;
	int quiet_cycles  = 0;
	int bytes_sent    = 0;
	int bytes_queued  = 0;
	int keys_matched  = 0;
	int pairs_matched = 0;
	int enable_writes = 0;
	int stall_cycles  = 0;
	int mismatches    = 0;

	// Decoder state as the testbench sees it.
	logic       joy_en    = 1'b1;
	logic       in_text   = 1'b0;
	logic [1:0] ln_count  = 2'd0;
	logic [7:0] ln_first  = 8'd0;
	logic [4:0] frm_count = 5'd0;
	logic [7:0] frm_buf [FRAME_DEPTH];

	serial_joystick_command_decoder_top #(
		.FRAME_BUF_DEPTH(FRAME_DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.rx_byte(rx_byte),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.empty(empty),
		.pop(pop),
		.result_kind(result_kind),
		.key_code(key_code),
		.straight_speed(straight_speed),
		.turn_speed(turn_speed)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic bit line_end(input logic [7:0] c);
		return c == sjcd_pkg::CH_CR || c == sjcd_pkg::CH_LF;
	endfunction

	function automatic bit key_allowed(input logic [7:0] c);
		case (c)
			sjcd_pkg::CH_UP_F, sjcd_pkg::CH_UP_B, sjcd_pkg::CH_UP_L, sjcd_pkg::CH_UP_R,
			sjcd_pkg::CH_UP_W, sjcd_pkg::CH_UP_X, sjcd_pkg::CH_UP_Y, sjcd_pkg::CH_UP_Z,
			sjcd_pkg::CH_UP_U, sjcd_pkg::CH_UP_S, sjcd_pkg::CH_UP_D: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic int sine_of_deg(input int a);
		int q;
		int r;
		int v;
		a = a % 360;
		q = a / 90;
		r = a % 90;
		v = int'(sjcd_pkg::SINE_Q15[(q % 2 == 1) ? 90 - r : r]);
		return (q >= 2) ? -v : v;
	endfunction

	function automatic logic [7:0] scaled_speed(input int s, input int power);
		longint mag;
		longint num;
		longint q;
		int v;
		mag = longint'((s < 0) ? -s : s);
		num = mag * power * 100;
		q = (2 * num + SPEED_DEN) / (2 * SPEED_DEN);
		v = (s < 0) ? -int'(q) : int'(q);
		return v[7:0];
	endfunction

	function automatic bit close_frame(output sjcd_pkg::res_t res);
		int angle;
		int power;
		int i;
		res = '0;
		angle = 0;
		power = 0;
		if (frm_count < 8 || frm_buf[4] != sjcd_pkg::CH_UP_P) begin
			return 1'b0;
		end
		for (i = 1; i <= 6; i++) begin
			if (i != 4) begin
				if (frm_buf[i] < sjcd_pkg::CH_ZERO || frm_buf[i] > sjcd_pkg::CH_NINE) begin
					return 1'b0;
				end
				if (i <= 3) begin
					angle = angle * 10 + int'(frm_buf[i] - sjcd_pkg::CH_ZERO);
				end else begin
					power = power * 10 + int'(frm_buf[i] - sjcd_pkg::CH_ZERO);
				end
			end
		end
		if (angle > 359 || power > 99) begin
			return 1'b0;
		end
		res.kind     = sjcd_pkg::KIND_JOY;
		res.straight = scaled_speed(sine_of_deg(angle), power);
		res.turn     = scaled_speed(sine_of_deg(angle + 90), power);
		return 1'b1;
	endfunction

	function automatic bit decode_byte(input logic [7:0] raw, output sjcd_pkg::res_t res);
		logic [7:0] c;
		bit hit;
		c = raw;
		hit = 1'b0;
		res = '0;
		if (c >= sjcd_pkg::CH_LO_A && c <= sjcd_pkg::CH_LO_Z) begin
			c = c - sjcd_pkg::CASE_GAP;
		end
		if (in_text) begin
			if (line_end(c)) begin
				if (ln_count == 2'd1 && key_allowed(ln_first)) begin
					res.kind = sjcd_pkg::KIND_KEY;
					res.key  = (ln_first == sjcd_pkg::CH_UP_D) ? sjcd_pkg::CH_UP_B : ln_first;
					hit = 1'b1;
				end
				in_text  = 1'b0;
				ln_count = 2'd0;
				ln_first = 8'd0;
			end else if (ln_count < 2'd2) begin
				if (ln_count == 2'd0) begin
					ln_first = c;
				end
				ln_count++;
			end
			return hit;
		end
		if (frm_count == 0 && line_end(c)) begin
			return 1'b0;
		end
		if (c == sjcd_pkg::CH_UP_A && joy_en) begin
			frm_buf[0] = c;
			frm_count = 5'd1;
			return 1'b0;
		end
		if (frm_count > 0 && frm_count < FRAME_DEPTH) begin
			frm_buf[frm_count[3:0]] = c;
			frm_count++;
			if (line_end(c)) begin
				hit = close_frame(res);
				frm_count = 5'd0;
			end
			if (frm_count >= FRAME_DEPTH) begin
				frm_count = 5'd0;
				in_text = 1'b1;
			end
			return hit;
		end
		in_text  = 1'b1;
		ln_count = 2'd0;
		ln_first = 8'd0;
		if (!line_end(c)) begin
			ln_first = c;
			ln_count = 2'd1;
		end
		return 1'b0;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatches++;
		$display("tb: mismatch at %0t: %s got %0d, wanted %0d", $time, what, got, want);
	endtask

	task automatic add_byte(input logic [7:0] b);
		tx_bytes.push_back(b);
		bytes_queued++;
	endtask

	task automatic add_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++) begin
			add_byte(s[i]);
		end
	endtask

	function automatic logic [7:0] filler();
		logic [7:0] b;
		b = 8'($urandom_range(255));
		while (b == sjcd_pkg::CH_CR || b == sjcd_pkg::CH_LF || b == sjcd_pkg::CH_UP_A ||
			b == sjcd_pkg::CH_LO_A) begin
			b = 8'($urandom_range(255));
		end
		return b;
	endfunction

	function automatic logic [7:0] pick_key();
		logic [7:0] k;
		case ($urandom_range(10))
			0: k = sjcd_pkg::CH_UP_F;
			1: k = sjcd_pkg::CH_UP_B;
			2: k = sjcd_pkg::CH_UP_L;
			3: k = sjcd_pkg::CH_UP_R;
			4: k = sjcd_pkg::CH_UP_W;
			5: k = sjcd_pkg::CH_UP_X;
			6: k = sjcd_pkg::CH_UP_Y;
			7: k = sjcd_pkg::CH_UP_Z;
			8: k = sjcd_pkg::CH_UP_U;
			9: k = sjcd_pkg::CH_UP_S;
			default: k = sjcd_pkg::CH_UP_D;
		endcase
		if ($urandom_range(3) == 0) begin
			k = k + sjcd_pkg::CASE_GAP;
		end
		return k;
	endfunction

	task automatic add_sequence();
		logic [7:0] fr [7];
		logic [7:0] term;
		int sel;
		int bad;
		int angle;
		int power;
		int extra;
		int i;
		sel   = $urandom_range(99);
		term  = $urandom_range(1) ? sjcd_pkg::CH_CR : sjcd_pkg::CH_LF;
		angle = $urandom_range(359);
		power = $urandom_range(99);
		extra = $urandom_range(8);
		if ($urandom_range(7) == 0) begin
			power = $urandom_range(1) ? 0 : 99;
		end
		if ($urandom_range(7) == 0) begin
			angle = $urandom_range(1) ? 359 : 90 * $urandom_range(3);
		end
		if (sel < 50 || sel >= 90) begin
			bad = (sel >= 40 && sel < 50) ? 1 + $urandom_range(3) : 0;
			if (bad == 1) begin
				angle = 360 + $urandom_range(639);
			end
			if (sel >= 90) begin
				// An 'A' inside a frame starts it over.
				add_byte(sjcd_pkg::CH_UP_A);
				repeat ($urandom_range(5)) add_byte(8'(sjcd_pkg::CH_ZERO + $urandom_range(9)));
			end
			fr[0] = $urandom_range(3) == 0 ? sjcd_pkg::CH_LO_A : sjcd_pkg::CH_UP_A;
			fr[1] = 8'(sjcd_pkg::CH_ZERO + angle / 100);
			fr[2] = 8'(sjcd_pkg::CH_ZERO + (angle / 10) % 10);
			fr[3] = 8'(sjcd_pkg::CH_ZERO + angle % 10);
			fr[4] = $urandom_range(3) == 0 ? sjcd_pkg::CH_UP_P + sjcd_pkg::CASE_GAP :
				sjcd_pkg::CH_UP_P;
			fr[5] = 8'(sjcd_pkg::CH_ZERO + power / 10);
			fr[6] = 8'(sjcd_pkg::CH_ZERO + power % 10);
			if (bad == 2) begin
				fr[1 + $urandom_range(5)] = filler();
			end
			if (bad == 3) begin
				fr[4] = filler();
			end
			for (i = 0; i < ((bad == 4) ? 6 : 7); i++) begin
				add_byte(fr[i]);
			end
			if (bad != 4) begin
				repeat (extra) add_byte(filler());
			end
			add_byte(term);
		end else if (sel < 72) begin
			add_byte(($urandom_range(7) == 0) ? filler() : pick_key());
			add_byte(term);
		end else if (sel < 78) begin
			add_byte(sjcd_pkg::CH_UP_A);
			repeat (15 + $urandom_range(5)) add_byte(filler());
			add_byte(term);
		end else begin
			repeat (1 + $urandom_range(3)) add_byte(8'($urandom_range(255)));
			if ($urandom_range(1)) begin
				add_byte(term);
			end
		end
	endtask

	task automatic add_random(input int count);
		int target;
		target = bytes_queued + count;
		while (bytes_queued < target) begin
			add_sequence();
		end
	endtask

	task automatic settle();
		while (tx_bytes.size() != 0 || push) @(posedge clk);
		while (awaited.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_enable(input logic value);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		joy_en    = value;
		frm_count = 5'd0;
		enable_writes++;
	endtask

	always @(posedge clk) begin : driver
		sjcd_pkg::res_t predicted;
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (push && !full) begin
				if (decode_byte(rx_byte, predicted)) begin
					awaited.push_back(predicted);
				end
				void'(tx_bytes.pop_front());
				bytes_sent++;
			end
			if (push && full) begin
				stall_cycles++;
			end else if (tx_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				push    <= 1'b1;
				rx_byte <= tx_bytes[0];
			end else begin
				push <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : monitor
		sjcd_pkg::res_t want;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (awaited.size() == 0) begin
					report_mismatch("result with none awaited, key_code", int'(key_code), 0);
				end else begin
					want = awaited.pop_front();
					if (result_kind !== want.kind) begin
						report_mismatch("result_kind", int'(result_kind), int'(want.kind));
					end
					if (key_code !== want.key) begin
						report_mismatch("key_code", int'(key_code), int'(want.key));
					end
					if (straight_speed !== want.straight) begin
						report_mismatch("straight_speed", int'(straight_speed),
							int'(want.straight));
					end
					if (turn_speed !== want.turn) begin
						report_mismatch("turn_speed", int'(turn_speed), int'(want.turn));
					end
					if (want.kind == sjcd_pkg::KIND_JOY) begin
						pairs_matched++;
					end else begin
						keys_matched++;
					end
				end
			end
			if (hold_requests != holds_served) begin
				holds_served = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if ((push && !full) || (pop && !empty)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb: timeout after %0d cycles with no item moving", quiet_cycles);
			$display("tb: failure");
			$finish;
		end
	end

	initial begin : stimulus
		arst_n      = 1'b0;
		push        = 1'b0;
		rx_byte     = 8'd0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = 1'b0;
		pop         = 1'b0;
		send_idle_pct = 34;
		recv_idle_pct = 82;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		write_enable(1'b1);

		add_text("a359p99");
		add_byte(sjcd_pkg::CH_LF);
		add_text("A000P00");
		add_byte(sjcd_pkg::CH_CR);
		add_text("d");
		add_byte(sjcd_pkg::CH_CR);
		add_byte(sjcd_pkg::CH_LF);
		add_byte(8'h00);
		add_byte(8'hFF);
		add_byte(sjcd_pkg::CH_CR);
		add_random(300);
		// Leave a frame open so that the next write has one to drop.
		add_text("A12");
		settle();

		write_enable(1'b0);
		send_idle_pct = 82;
		recv_idle_pct = 34;
		add_random(150);
		settle();

		write_enable(1'b1);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (80) begin
			add_byte(pick_key());
			add_byte(sjcd_pkg::CH_CR);
		end
		hold_requests++;
		settle();
		add_random(240);
		settle();

		if (awaited.size() != 0) begin
			report_mismatch("results never delivered", 0, awaited.size());
		end
		$display("tb: %0d bytes decoded, %0d key commands and %0d speed pairs matched",
			bytes_sent, keys_matched, pairs_matched);
		$display("tb: %0d enable writes, %0d cycles with input stalled, %0d mismatches",
			enable_writes, stall_cycles, mismatches);
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// ===== serial_joystick_command_decoder_top.f =====
src/sjcd_pkg.sv
src/sjcd_fifo.sv
src/sjcd_front.sv
src/sjcd_back.sv
src/serial_joystick_command_decoder_top.sv
sim/serial_joystick_command_decoder_top_tb.sv
